// ===== rtl/lcpt_pkg.sv =====
// lcpt_pkg: shared types, register codes, reset values and the cosine
// table generator for the LFM chirp pulse train. No dependencies.
`default_nettype none

package lcpt_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_AMPLITUDE    = 3'd0,
    CFG_CHIRP_STEP   = 3'd1,
    CFG_PULSE_LENGTH = 3'd2,
    CFG_PULSE_PERIOD = 3'd3,
    CFG_PULSE_COUNT  = 3'd4
  } cfg_reg_e;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;
  localparam int AmpBits     = 15;
  localparam int StepBits    = 32;
  localparam int LenBits     = 16;
  localparam int PeriodBits  = 20;
  localparam int CountBits   = 8;
  localparam int PhaseBits   = 32;

  localparam logic [AmpBits-1:0]    AmpReset    = 15'd32767;
  localparam logic [StepBits-1:0]   StepReset   = 32'd26214;
  localparam logic [LenBits-1:0]    LenReset    = 16'd1280;
  localparam logic [PeriodBits-1:0] PeriodReset = 20'd14080;
  localparam logic [CountBits-1:0]  CountReset  = 8'd3;

  // Depth of both word queues
  localparam int QueueDepth   = 4;
  localparam int QueueCntBits = 3;

  // Per-tick control that travels with the table index
  typedef struct packed {
    logic active;  // chirp sample
    logic last;    // final sample of the train
  } ctl_t;

  localparam longint unsigned Q30One    = 64'd1073741824;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  function automatic longint unsigned mulq(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // 1 - p in Q30, floored at zero
  function automatic longint unsigned one_sub(longint unsigned p);
    return (p >= Q30One) ? 64'd0 : (Q30One - p);
  endfunction

  function automatic longint unsigned cos_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = mulq(x, x);
    t  = one_sub(mulq(x2, Q30One) / 64'd90);
    t  = one_sub(mulq(x2, t) / 64'd56);
    t  = one_sub(mulq(x2, t) / 64'd30);
    t  = one_sub(mulq(x2, t) / 64'd12);
    t  = one_sub(mulq(x2, t) / 64'd2);
    return t;
  endfunction

  function automatic longint unsigned sin_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = mulq(x, x);
    t  = one_sub(mulq(x2, Q30One) / 64'd110);
    t  = one_sub(mulq(x2, t) / 64'd72);
    t  = one_sub(mulq(x2, t) / 64'd42);
    t  = one_sub(mulq(x2, t) / 64'd20);
    t  = one_sub(mulq(x2, t) / 64'd6);
    return mulq(x, t);
  endfunction

  // Table entry k: bit 31 is the sign, the low bits the rounded magnitude.
  // Evaluated at elaboration only.
  function automatic logic [31:0] cos_entry(int unsigned k, int tbits, int sbits);
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned v;
    longint unsigned m;
    longint unsigned maxmag;
    int              qbits;
    int              fshift;
    logic            neg;
    qbits  = tbits - 2;
    fshift = 31 - sbits;
    maxmag = (64'd1 << (sbits - 1)) - 64'd1;
    quad   = longint'(k) >> qbits;
    r      = longint'(k) & ((64'd1 << qbits) - 64'd1);
    x      = (r * HalfPiQ30) >> qbits;
    v      = quad[0] ? sin_q30(x) : cos_q30(x);
    m      = (v + (64'd1 << (fshift - 1))) >> fshift;
    if (m > maxmag) begin
      m = maxmag;
    end
    neg = ((quad == 64'd1) || (quad == 64'd2)) && (m != 64'd0);
    return {neg, m[30:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lfm_chirp_pulse_train.sv =====
// lfm_chirp_pulse_train: top level, configuration registers and the two
// word queues. Instantiates lcpt_front, lcpt_fifo, lcpt_back; uses lcpt_pkg.
`default_nettype none

// Linear-FM chirp pulse train generator. Every tick pushed in yields exactly
// one sample word, in order: amplitude times the cosine of a quadratic phase
// during each chirp, zero elsewhere, with in_pulse and train_last flags. A
// tick is taken every clock while full is low; the sequencer decides each
// tick in the cycle it is accepted and hands it to a four-word queue. The
// sample path (table read, one 15 x (SAMPLE_BITS-1) multiply, round) registers
// the table read and then the product and rounds combinationally, and the result
// side also sustains one word per clock while results are popped. full rises only
// when results are not popped and both queues back up. The cosine table has
// 2^COS_TABLE_BITS entries and is built at elaboration. Write the
// configuration registers only while no train words are outstanding.
module lfm_chirp_pulse_train #(
  parameter int COS_TABLE_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lcpt_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [lcpt_pkg::CfgDataBits-1:0] cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  logic                             start_req_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [SAMPLE_BITS-1:0]    sample_o,
  output logic                             in_pulse_o,
  output logic                             train_last_o
);

  localparam int CmdW = COS_TABLE_BITS + $bits(lcpt_pkg::ctl_t);
  localparam int OutW = SAMPLE_BITS + $bits(lcpt_pkg::ctl_t);

  logic [lcpt_pkg::AmpBits-1:0]    amp_q;
  logic [lcpt_pkg::StepBits-1:0]   step_q;
  logic [lcpt_pkg::LenBits-1:0]    len_q;
  logic [lcpt_pkg::PeriodBits-1:0] period_q;
  logic [lcpt_pkg::CountBits-1:0]  count_q;

  logic                  accept;
  logic [COS_TABLE_BITS-1:0] fr_idx, cmd_idx;
  lcpt_pkg::ctl_t        fr_ctl, cmd_ctl, bk_ctl, res_ctl;
  logic                  cmd_empty, cmd_pop;
  logic [lcpt_pkg::QueueCntBits-1:0] cmd_count, out_count;
  logic                  out_push, out_full;
  logic signed [SAMPLE_BITS-1:0] bk_sample;
  logic [SAMPLE_BITS-1:0] res_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q    <= lcpt_pkg::AmpReset;
      step_q   <= lcpt_pkg::StepReset;
      len_q    <= lcpt_pkg::LenReset;
      period_q <= lcpt_pkg::PeriodReset;
      count_q  <= lcpt_pkg::CountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcpt_pkg::CFG_AMPLITUDE:    amp_q    <= cfg_wdata_i[lcpt_pkg::AmpBits-1:0];
        lcpt_pkg::CFG_CHIRP_STEP:   step_q   <= cfg_wdata_i[lcpt_pkg::StepBits-1:0];
        lcpt_pkg::CFG_PULSE_LENGTH: len_q    <= cfg_wdata_i[lcpt_pkg::LenBits-1:0];
        lcpt_pkg::CFG_PULSE_PERIOD: period_q <= cfg_wdata_i[lcpt_pkg::PeriodBits-1:0];
        lcpt_pkg::CFG_PULSE_COUNT:  count_q  <= cfg_wdata_i[lcpt_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  lcpt_front #(
    .TABLE_BITS (COS_TABLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .start_req_i    (start_req_i),
    .chirp_step_i   (step_q),
    .pulse_length_i (len_q),
    .pulse_period_i (period_q),
    .pulse_count_i  (count_q),
    .idx_o          (fr_idx),
    .ctl_o          (fr_ctl)
  );

  lcpt_fifo #(
    .WIDTH    (CmdW),
    .DEPTH    (lcpt_pkg::QueueDepth),
    .CNT_BITS (lcpt_pkg::QueueCntBits)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i ({fr_idx, fr_ctl}),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o ({cmd_idx, cmd_ctl}),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  lcpt_back #(
    .TABLE_BITS  (COS_TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_idx_i    (cmd_idx),
    .cmd_ctl_i    (cmd_ctl),
    .cmd_pop_o    (cmd_pop),
    .amplitude_i  (amp_q),
    .out_count_i  (out_count),
    .out_push_o   (out_push),
    .out_sample_o (bk_sample),
    .out_ctl_o    (bk_ctl)
  );

  lcpt_fifo #(
    .WIDTH    (OutW),
    .DEPTH    (lcpt_pkg::QueueDepth),
    .CNT_BITS (lcpt_pkg::QueueCntBits)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i ({bk_sample, bk_ctl}),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o ({res_sample, res_ctl}),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign sample_o     = $signed(res_sample);
  assign in_pulse_o   = res_ctl.active;
  assign train_last_o = res_ctl.last;

  // Result queue credit must never be overrun by the sample pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_push |-> !out_full)
    else $error("result word pushed into a full queue");

  // Between chirps the sample word is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && !bk_ctl.active) |-> (bk_sample == '0))
    else $error("nonzero sample outside a chirp");

  // A tick word can only leave the command queue if one was there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_count == '0) |-> !cmd_pop)
    else $error("command pop from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/lcpt_fifo.sv =====
// lcpt_fifo: small synchronous word queue with occupancy count.
// Uses lcpt_pkg only through its parameters at the instance.
`default_nettype none

module lcpt_fifo #(
  parameter int WIDTH    = 8,
  parameter int DEPTH    = 4,
  parameter int CNT_BITS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    rdata_o,
  output logic                empty_o,
  output logic [CNT_BITS-1:0] count_o
);

  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [AddrBits-1:0] wr_q, wr_d;
  logic [AddrBits-1:0] rd_q, rd_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CNT_BITS'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AddrBits'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AddrBits'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcpt_cos_rom.sv =====
// lcpt_cos_rom: sign-magnitude cosine table with registered read.
// Contents come from lcpt_pkg::cos_entry at elaboration.
`default_nettype none

module lcpt_cos_rom #(
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic [TABLE_BITS-1:0]  addr_i,
  output logic                   neg_o,
  output logic [SAMPLE_BITS-2:0] mag_o
);

  localparam int TableSize = 1 << TABLE_BITS;

  logic [SAMPLE_BITS-1:0] rom_tab [TableSize];
  logic [SAMPLE_BITS-1:0] data_q;

  for (genvar k = 0; k < TableSize; k++) begin : g_tab
    localparam logic [31:0] Entry = lcpt_pkg::cos_entry(k, TABLE_BITS, SAMPLE_BITS);
    assign rom_tab[k] = {Entry[31], Entry[SAMPLE_BITS-2:0]};
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_tab[addr_i];
  end

  assign neg_o = data_q[SAMPLE_BITS-1];
  assign mag_o = data_q[SAMPLE_BITS-2:0];

endmodule

`default_nettype wire

// ===== rtl/lcpt_front.sv =====
// lcpt_front: train/period sequencer and second-order phase accumulator.
// Turns each accepted tick into a table index plus control. Uses lcpt_pkg.
`default_nettype none

module lcpt_front #(
  parameter int TABLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            start_req_i,
  input  logic [lcpt_pkg::StepBits-1:0]   chirp_step_i,
  input  logic [lcpt_pkg::LenBits-1:0]    pulse_length_i,
  input  logic [lcpt_pkg::PeriodBits-1:0] pulse_period_i,
  input  logic [lcpt_pkg::CountBits-1:0]  pulse_count_i,
  output logic [TABLE_BITS-1:0]           idx_o,
  output lcpt_pkg::ctl_t                  ctl_o
);

  localparam int PB = lcpt_pkg::PeriodBits;
  localparam int CB = lcpt_pkg::CountBits;
  localparam int HB = lcpt_pkg::PhaseBits;

  logic [PB-1:0] sidx_q, sidx_d, sidx_c;
  logic [CB-1:0] pidx_q, pidx_d, pidx_c;
  logic [HB-1:0] phase_q, phase_d, phase_c;
  logic [HB-1:0] freq_q, freq_d, freq_c;
  logic          run_q, run_d, run_c;
  logic          period_end, final_pulse, active;

  // Current view, with a start request restarting the train on this tick
  always_comb begin
    sidx_c  = start_req_i ? '0 : sidx_q;
    pidx_c  = start_req_i ? '0 : pidx_q;
    phase_c = start_req_i ? '0 : phase_q;
    freq_c  = start_req_i ? '0 : freq_q;
    run_c   = start_req_i || run_q;
  end

  assign period_end  = ({1'b0, sidx_c} + 1'b1) >= {1'b0, pulse_period_i};
  assign final_pulse = ({1'b0, pidx_c} + 1'b1) >= {1'b0, pulse_count_i};
  assign active      = run_c && ({{(PB-lcpt_pkg::LenBits){1'b0}}, pulse_length_i} > sidx_c);

  assign idx_o = phase_c[HB-1 -: TABLE_BITS];
  assign ctl_o = '{active: active, last: run_c && period_end && final_pulse};

  always_comb begin
    sidx_d  = sidx_c;
    pidx_d  = pidx_c;
    phase_d = phase_c;
    freq_d  = freq_c;
    run_d   = run_c;
    if (run_c) begin
      if (active) begin
        phase_d = phase_c + freq_c;
        freq_d  = freq_c + chirp_step_i;
      end
      if (period_end) begin
        sidx_d  = '0;
        phase_d = '0;
        freq_d  = '0;
        if (final_pulse) begin
          run_d  = 1'b0;
          pidx_d = '0;
        end else begin
          pidx_d = pidx_c + 1'b1;
        end
      end else begin
        sidx_d = sidx_c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidx_q  <= '0;
      pidx_q  <= '0;
      phase_q <= '0;
      freq_q  <= '0;
      run_q   <= 1'b0;
    end else if (accept_i) begin
      sidx_q  <= sidx_d;
      pidx_q  <= pidx_d;
      phase_q <= phase_d;
      freq_q  <= freq_d;
      run_q   <= run_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcpt_back.sv =====
// lcpt_back: table lookup, amplitude scaling, rounding and sign.
// Instantiates lcpt_cos_rom; uses lcpt_pkg. Feeds the result queue.
`default_nettype none

module lcpt_back #(
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_empty_i,
  input  logic [TABLE_BITS-1:0]             cmd_idx_i,
  input  lcpt_pkg::ctl_t                    cmd_ctl_i,
  output logic                              cmd_pop_o,
  input  logic [lcpt_pkg::AmpBits-1:0]      amplitude_i,
  input  logic [lcpt_pkg::QueueCntBits-1:0] out_count_i,
  output logic                              out_push_o,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_o,
  output lcpt_pkg::ctl_t                    out_ctl_o
);

  localparam int MB = SAMPLE_BITS - 1;
  localparam int PW = lcpt_pkg::AmpBits + MB;
  localparam int CW = lcpt_pkg::QueueCntBits + 1;

  logic           v1_q, v2_q;
  lcpt_pkg::ctl_t ctl1_q, ctl2_q;
  logic           neg2_q;
  logic [PW-1:0]  prod_q;
  logic           rom_neg;
  logic [MB-1:0]  rom_mag;
  logic [CW-1:0]  pending;
  logic [PW:0]    rnd;
  logic [PW:0]    shifted;
  logic [SAMPLE_BITS-1:0] mag;

  // Words in flight plus those queued must fit the result queue
  assign pending   = {1'b0, out_count_i} + CW'(v1_q) + CW'(v2_q);
  assign cmd_pop_o = !cmd_empty_i && (pending < CW'(lcpt_pkg::QueueDepth));

  lcpt_cos_rom #(
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (cmd_idx_i),
    .neg_o  (rom_neg),
    .mag_o  (rom_mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_pop_o;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl1_q <= cmd_ctl_i;
    ctl2_q <= ctl1_q;
    neg2_q <= rom_neg;
    prod_q <= PW'(amplitude_i) * PW'(rom_mag);
  end

  assign rnd     = {1'b0, prod_q} + ((PW+1)'(1) << (SAMPLE_BITS - 2));
  assign shifted = rnd >> MB;
  assign mag     = shifted[SAMPLE_BITS-1:0];

  always_comb begin
    if (!ctl2_q.active) begin
      out_sample_o = '0;
    end else if (neg2_q) begin
      out_sample_o = -$signed(mag);
    end else begin
      out_sample_o = $signed(mag);
    end
  end

  assign out_push_o = v2_q;
  assign out_ctl_o  = ctl2_q;

endmodule

`default_nettype wire

// ===== tb/sv/lfm_chirp_pulse_train_tb.sv =====
// lfm_chirp_pulse_train_tb: self-checking testbench for the LFM chirp pulse train.
// Holds its own chirp/cosine predictor and drives both word queues with random
// idling. Depends on lcpt_pkg and lfm_chirp_pulse_train.
`timescale 1ns / 100ps

module lfm_chirp_pulse_train_tb;

  localparam int TabBits = 10;
  localparam int SmpBits = 16;
  localparam int TabSize = 1 << TabBits;
  localparam longint unsigned Q30Unity = 64'd1 << 30;
  localparam longint unsigned QuarterTurnQ30 = 64'd1686629713;
  localparam int CycleLimit = 200000;
  localparam int LongHold = 400;

  typedef struct packed {
    logic signed [SmpBits-1:0] sample;
    logic                      in_pulse;
    logic                      train_last;
  } sample_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [lcpt_pkg::CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [lcpt_pkg::CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic                   start_req_i = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic signed [SmpBits-1:0] sample_o;
  logic                   in_pulse_o;
  logic                   train_last_o;

  lfm_chirp_pulse_train #(
    .COS_TABLE_BITS(TabBits),
    .SAMPLE_BITS   (SmpBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .start_req_i (start_req_i),
    .empty       (empty),
    .pop         (pop),
    .sample_o    (sample_o),
    .in_pulse_o  (in_pulse_o),
    .train_last_o(train_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and register copies
  logic [14:0] amp_r;
  logic [31:0] step_r;
  logic [15:0] len_r;
  logic [19:0] period_r;
  logic [7:0]  count_r;
  logic [19:0] pos_in_period;
  logic [7:0]  pulse_num;
  logic [31:0] phase;
  logic [31:0] phase_inc;
  logic        train_on = 1'b0;

  logic [SmpBits-2:0] cos_mag_tab [TabSize];
  logic               cos_neg_tab [TabSize];

  bit           pending_ticks[$];
  sample_word_t expected_words[$];

  int items_done = 0;
  int words_checked = 0;
  int fail_cnt = 0;
  int starts_sent = 0;
  int chirp_words = 0;
  int train_ends = 0;
  int cycle_cnt = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Nested Taylor form: t = 1 - x^2*t/d over the divisor chain, odd series times x
  function automatic longint unsigned taylor_q30(longint unsigned x, bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned p;
    longint unsigned divs [5];
    x2 = q30_mul(x, x);
    if (odd) begin
      divs = '{110, 72, 42, 20, 6};
    end else begin
      divs = '{90, 56, 30, 12, 2};
    end
    term = Q30Unity;
    for (int i = 0; i < 5; i++) begin
      p = q30_mul(x2, term) / divs[i];
      term = (p >= Q30Unity) ? 64'd0 : Q30Unity - p;
    end
    return odd ? q30_mul(x, term) : term;
  endfunction

  initial begin
    longint unsigned quad, frac, x, v, m;
    for (int k = 0; k < TabSize; k++) begin
      quad = longint'(k) >> (TabBits - 2);
      frac = longint'(k) & ((64'd1 << (TabBits - 2)) - 1);
      x = (frac * QuarterTurnQ30) >> (TabBits - 2);
      v = taylor_q30(x, quad[0]);
      m = (v + (64'd1 << (30 - SmpBits))) >> (31 - SmpBits);
      if (m > (64'd1 << (SmpBits - 1)) - 1) m = (64'd1 << (SmpBits - 1)) - 1;
      cos_mag_tab[k] = m[SmpBits-2:0];
      cos_neg_tab[k] = (quad == 1 || quad == 2) && m != 0;
    end
  end

  function automatic void next_chirp_word(input logic start, output sample_word_t w);
    bit          period_end;
    bit          final_pulse;
    logic [TabBits-1:0] idx;
    logic [31:0] prod;
    logic [31:0] mag;
    w = '0;
    if (start) begin
      pos_in_period = '0;
      pulse_num = '0;
      phase = '0;
      phase_inc = '0;
      train_on = 1'b1;
    end
    if (train_on) begin
      period_end = (32'(pos_in_period) + 1) >= 32'(period_r);
      final_pulse = (32'(pulse_num) + 1) >= 32'(count_r);
      if (32'(pos_in_period) < 32'(len_r)) begin
        idx = phase[31 -: TabBits];
        prod = 32'(amp_r) * 32'(cos_mag_tab[idx]);
        mag = (prod + (32'd1 << (SmpBits - 2))) >> (SmpBits - 1);
        w.sample = cos_neg_tab[idx] ? -mag[SmpBits-1:0] : mag[SmpBits-1:0];
        w.in_pulse = 1'b1;
        phase = phase + phase_inc;
        phase_inc = phase_inc + step_r;
        chirp_words++;
      end
      if (period_end) begin
        pos_in_period = '0;
        phase = '0;
        phase_inc = '0;
        if (final_pulse) begin
          w.train_last = 1'b1;
          train_on = 1'b0;
          pulse_num = '0;
          train_ends++;
        end else begin
          pulse_num = pulse_num + 1;
        end
      end else begin
        pos_in_period = pos_in_period + 1;
      end
    end
  endfunction

  // idle percentages per stretch of the run
  function automatic int sender_idle_pct();
    if (items_done < 340) return 23;
    if (items_done < 680) return 53;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (items_done < 340) return 53;
    if (items_done < 680) return 23;
    return 0;
  endfunction

  // Tick driver
  always @(posedge clk_i) begin
    sample_word_t w;
    bit offer;
    if (rst_ni) begin
      if (push && !full) begin
        next_chirp_word(start_req_i, w);
        expected_words.insert(expected_words.size(), w);
        items_done++;
        if (start_req_i) starts_sent++;
        void'(pending_ticks.pop_front());
      end
      offer = pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct();
      push <= offer;
      start_req_i <= offer ? pending_ticks[0] : 1'b0;
    end
  end

  // Word monitor
  always @(posedge clk_i) begin
    sample_word_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected word: sample %0d in_pulse %0b train_last %0b",
                     sample_o, in_pulse_o, train_last_o);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (sample_o !== want.sample || in_pulse_o !== want.in_pulse ||
              train_last_o !== want.train_last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("word %0d mismatch: exp sample %0d in_pulse %0b last %0b, got %0d %0b %0b",
                       words_checked, want.sample, want.in_pulse, want.train_last,
                       sample_o, in_pulse_o, train_last_o);
          end
        end
      end
      if (hold_served < hold_asked) begin
        hold_served++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= $urandom_range(99) >= receiver_idle_pct();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               expected_words.size());
      $display("[lfm_chirp_pulse_train] ERROR");
      $finish;
    end
  end

  // Writes all five registers back to back; noisy sometimes adds junk above a width
  task automatic configure(logic [31:0] amp, logic [31:0] stp, logic [31:0] len,
                           logic [31:0] per, logic [31:0] cnt, bit noisy);
    logic [31:0] vals [5];
    int          widths [5];
    logic [31:0] mask;
    vals = '{amp, stp, len, per, cnt};
    widths = '{lcpt_pkg::AmpBits, lcpt_pkg::StepBits, lcpt_pkg::LenBits,
               lcpt_pkg::PeriodBits, lcpt_pkg::CountBits};
    for (int i = 0; i < 5; i++) begin
      mask = (widths[i] >= 32) ? 32'hFFFF_FFFF : ((32'd1 << widths[i]) - 1);
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= lcpt_pkg::cfg_reg_e'(i);
      cfg_wdata_i <= (vals[i] & mask) |
                     ((noisy && $urandom_range(3) == 0) ? ($urandom() & ~mask) : 32'd0);
    end
    amp_r = amp[14:0];
    step_r = stp;
    len_r = len[15:0];
    period_r = per[19:0];
    count_r = cnt[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_ticks(bit lead_start, int n, int start_pct);
    @(negedge clk_i);
    for (int i = 0; i < n; i++)
      pending_ticks.insert(pending_ticks.size(),
                           (i == 0) ? lead_start : ($urandom_range(99) < start_pct));
  endtask

  // Sender pauses here until every expected word is back
  task automatic drain();
    while (pending_ticks.size() != 0 || expected_words.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                       logic [31:0] d);
    case ($urandom_range(3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  initial begin
    logic [31:0] amp, stp, len, per, cnt;
    amp_r = lcpt_pkg::AmpReset;
    step_r = lcpt_pkg::StepReset;
    len_r = lcpt_pkg::LenReset;
    period_r = lcpt_pkg::PeriodReset;
    count_r = lcpt_pkg::CountReset;
    pos_in_period = '0;
    pulse_num = '0;
    phase = '0;
    phase_inc = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset values: idle tick, then a train start
    @(negedge clk_i);
    pending_ticks = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    drain();
    // period shorter than the pulse, full-scale step, train runs out
    configure(32767, 32'hFFFF_FFFF, 5, 3, 2, 1'b0);
    @(negedge clk_i);
    pending_ticks = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    drain();
    // zero amplitude, zero length, zero period, zero count
    configure(0, 32'h1234_5678, 0, 0, 0, 1'b0);
    @(negedge clk_i);
    pending_ticks = '{1'b1, 1'b0, 1'b0};
    drain();
    // largest sizes, then a restart while running
    configure(12345, 32'h0040_0000, 65535, 1048575, 255, 1'b0);
    @(negedge clk_i);
    pending_ticks = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    drain();
    // change mid-train: new period already passed ends this period
    configure(20000, 32'h8000_0000, 2, 1, 3, 1'b0);
    @(negedge clk_i);
    pending_ticks = '{1'b0, 1'b0, 1'b0, 1'b0};
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      if ($urandom_range(7) == 0) begin
        amp = $urandom_range(1) ? 32767 : 0;
        stp = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom();
        len = pick(0, 1, 65535, $urandom_range(40));
        per = pick(0, 1, 1048575, $urandom_range(40));
        cnt = pick(0, 1, 255, $urandom_range(6));
      end else begin
        amp = $urandom_range(32767);
        stp = $urandom();
        len = $urandom_range(24);
        per = $urandom_range(32);
        cnt = $urandom_range(6);
      end
      configure(amp, stp, len, per, cnt, 1'b1);
      if (ph == 3) begin
        // long receiver stall while ticks keep coming
        queue_ticks(1'b1, 80, 3);
        @(negedge clk_i);
        hold_asked++;
      end else begin
        queue_ticks($urandom_range(99) < 75, 40, 3);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("%0d ticks (%0d starts), %0d words checked, %0d chirp samples, %0d trains ended",
             items_done, starts_sent, words_checked, chirp_words, train_ends);
    if (fail_cnt == 0 && expected_words.size() == 0) begin
      $display("[lfm_chirp_pulse_train] OK");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("[lfm_chirp_pulse_train] ERROR");
    end
    $finish;
  end

endmodule
